>>> rtl/chbd_pkg.sv
// shared types, constants and byte classifiers for the chunked body decoder
package chbd_pkg;

  // width of the chunk size counter
  localparam int COUNT_BITS = 32;
  // width used when the chunk size is compared with the remaining budget
  localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  localparam logic [31:0] BODY_LIMIT_RESET = 32'd16777216;

  // characters of interest
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_OK      = 2'd1,
    KIND_FAIL    = 2'd2
  } kind_t;

  // one input beat
  typedef struct packed {
    logic [7:0] body_byte;
    logic       is_final;
  } beat_t;

  // one result beat
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] body_length;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // nibble value of a hex digit, only meaningful when is_hex holds
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic is_token_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a) ||
           (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e});
  endfunction

endpackage

>>> rtl/chbd_in_stage.sv
// input register: holds one accepted beat until the decoder takes it
module chbd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_body_byte,
  input  logic            in_is_final,
  input  logic            take,
  output logic            vld,
  output chbd_pkg::beat_t beat
);
  import chbd_pkg::*;

  logic  vld_r;
  beat_t beat_r;

  // stall only while a held beat cannot move on this cycle
  assign in_stall = vld_r & ~take;
  assign vld      = vld_r;
  assign beat     = beat_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat_r.body_byte <= in_body_byte;
      beat_r.is_final  <= in_is_final;
    end
  end

endmodule

>>> rtl/chbd_core.sv
// per-byte parser state machine: size lines, payload, trailers and limit check
module chbd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [31:0]        cfg_data,
  input  logic               step,
  input  chbd_pkg::beat_t    beat,
  output logic               res_vld,
  output chbd_pkg::res_t     res
);
  import chbd_pkg::*;

  typedef enum logic [3:0] {
    PH_SIZE, PH_SIZE_TRAIL, PH_SIZE_CR, PH_EXT, PH_EXT_CR, PH_DATA,
    PH_DATA_CR, PH_DATA_LF, PH_T_NAME, PH_T_VALUE, PH_T_LINE_CR,
    PH_T_END_CR, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {EV_NONE, EV_PAYLOAD, EV_FAIL, EV_OK} ev_t;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] chunk_left_r, chunk_left_nxt;
  logic                  size_too_big_r, size_too_big_nxt;
  logic                  size_has_digit_r, size_has_digit_nxt;
  logic                  name_has_char_r, name_has_char_nxt;
  logic [31:0]           decoded_total_r, decoded_total_nxt;
  logic [31:0]           body_limit_r;

  logic [7:0]            b;
  logic                  fin;
  ev_t                   ev;
  logic                  restart;
  logic                  chunk_zero;
  logic [31:0]           remain;
  logic [CMP_W-1:0]      chunk_ext;
  logic [CMP_W-1:0]      remain_ext;
  logic                  eol_fail;

  assign b   = beat.body_byte;
  assign fin = beat.is_final;

  // end of size line checks against the body limit
  assign chunk_zero = (chunk_left_r == '0);
  assign remain     = body_limit_r - decoded_total_r;
  assign chunk_ext  = CMP_W'(chunk_left_r);
  assign remain_ext = CMP_W'(remain);
  assign eol_fail   = size_too_big_r ||
                      (!chunk_zero && ((decoded_total_r > body_limit_r) ||
                                       (chunk_ext > remain_ext)));

  // next state and result
  always_comb begin
    phase_nxt          = phase_r;
    chunk_left_nxt     = chunk_left_r;
    size_too_big_nxt   = size_too_big_r;
    size_has_digit_nxt = size_has_digit_r;
    name_has_char_nxt  = name_has_char_r;
    decoded_total_nxt  = decoded_total_r;
    ev                 = EV_NONE;
    restart            = 1'b0;
    res_vld            = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.body_length    = 32'd0;

    if (phase_r == PH_ERROR) begin
      // swallow bytes until the final one
      restart = fin;
    end else begin
      case (phase_r)
        PH_SIZE: begin
          if (is_hex(b)) begin
            size_has_digit_nxt = 1'b1;
            if (!size_too_big_r) begin
              if (chunk_left_r[COUNT_BITS-1 -: 4] != 4'd0) begin
                size_too_big_nxt = 1'b1;
              end else begin
                chunk_left_nxt = {chunk_left_r[COUNT_BITS-5:0], hex_nibble(b)};
              end
            end
          end else if (is_blank(b)) begin
            if (size_has_digit_r) phase_nxt = PH_SIZE_TRAIL;
          end else if (b == CH_SEMI) begin
            if (size_has_digit_r) phase_nxt = PH_EXT;
            else ev = EV_FAIL;
          end else if (b == CH_CR) begin
            if (size_has_digit_r) phase_nxt = PH_SIZE_CR;
            else ev = EV_FAIL;
          end else begin
            ev = EV_FAIL;
          end
        end
        PH_SIZE_TRAIL: begin
          if (is_blank(b)) begin
            phase_nxt = PH_SIZE_TRAIL;
          end else if (b == CH_SEMI) begin
            phase_nxt = PH_EXT;
          end else if (b == CH_CR) begin
            phase_nxt = PH_SIZE_CR;
          end else begin
            ev = EV_FAIL;
          end
        end
        PH_SIZE_CR, PH_EXT_CR: begin
          if (b == CH_LF) begin
            if (eol_fail) begin
              ev = EV_FAIL;
            end else if (chunk_zero) begin
              name_has_char_nxt = 1'b0;
              phase_nxt         = PH_T_NAME;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else if (phase_r == PH_SIZE_CR) begin
            ev = EV_FAIL;
          end else if (b != CH_CR) begin
            phase_nxt = PH_EXT;
          end
        end
        PH_EXT: begin
          if (b == CH_CR) phase_nxt = PH_EXT_CR;
        end
        PH_DATA: begin
          ev                = EV_PAYLOAD;
          decoded_total_nxt = decoded_total_r + 32'd1;
          chunk_left_nxt    = chunk_left_r - COUNT_BITS'(1);
          if (chunk_left_r == COUNT_BITS'(1)) phase_nxt = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b == CH_CR) phase_nxt = PH_DATA_LF;
          else ev = EV_FAIL;
        end
        PH_DATA_LF: begin
          if (b == CH_LF) begin
            phase_nxt          = PH_SIZE;
            chunk_left_nxt     = '0;
            size_too_big_nxt   = 1'b0;
            size_has_digit_nxt = 1'b0;
          end else begin
            ev = EV_FAIL;
          end
        end
        PH_T_NAME: begin
          if (b == CH_CR && !name_has_char_r) begin
            phase_nxt = PH_T_END_CR;
          end else if (is_token_char(b)) begin
            name_has_char_nxt = 1'b1;
          end else if (b == CH_COLON && name_has_char_r) begin
            phase_nxt = PH_T_VALUE;
          end else begin
            ev = EV_FAIL;
          end
        end
        PH_T_VALUE: begin
          if (b == CH_CR) begin
            phase_nxt = PH_T_LINE_CR;
          end else if (b != CH_HT && (b < CH_SP || b == CH_DEL)) begin
            ev = EV_FAIL;
          end
        end
        PH_T_LINE_CR: begin
          if (b == CH_LF) begin
            name_has_char_nxt = 1'b0;
            phase_nxt         = PH_T_NAME;
          end else begin
            ev = EV_FAIL;
          end
        end
        PH_T_END_CR: begin
          if (b == CH_LF && fin) ev = EV_OK;
          else ev = EV_FAIL;
        end
        default: begin
          ev = EV_FAIL;
        end
      endcase

      // turn the event into a result beat
      if (ev == EV_FAIL) begin
        res_vld  = 1'b1;
        res.kind = KIND_FAIL;
        if (fin) restart = 1'b1;
        else phase_nxt = PH_ERROR;
      end else if (ev == EV_OK) begin
        res_vld         = 1'b1;
        res.kind        = KIND_OK;
        res.body_length = decoded_total_r;
        restart         = 1'b1;
      end else if (fin) begin
        res_vld  = 1'b1;
        res.kind = KIND_FAIL;
        restart  = 1'b1;
      end else if (ev == EV_PAYLOAD) begin
        res_vld          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = b;
      end
    end

    // back to the start for the next body
    if (restart) begin
      phase_nxt          = PH_SIZE;
      chunk_left_nxt     = '0;
      size_too_big_nxt   = 1'b0;
      size_has_digit_nxt = 1'b0;
      name_has_char_nxt  = 1'b0;
      decoded_total_nxt  = 32'd0;
    end
  end

  // parser state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SIZE;
      chunk_left_r     <= '0;
      size_too_big_r   <= 1'b0;
      size_has_digit_r <= 1'b0;
      name_has_char_r  <= 1'b0;
      decoded_total_r  <= 32'd0;
      body_limit_r     <= BODY_LIMIT_RESET;
    end else begin
      if (cfg_wr) begin
        body_limit_r <= cfg_data;
      end
      if (step) begin
        phase_r          <= phase_nxt;
        chunk_left_r     <= chunk_left_nxt;
        size_too_big_r   <= size_too_big_nxt;
        size_has_digit_r <= size_has_digit_nxt;
        name_has_char_r  <= name_has_char_nxt;
        decoded_total_r  <= decoded_total_nxt;
      end
    end
  end

endmodule

>>> rtl/chbd_out_stage.sv
// result register: holds one result beat until the consumer takes it
module chbd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic           res_vld,
  input  chbd_pkg::res_t res,
  output logic           free,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_payload_byte,
  output logic [31:0]    out_body_length
);
  import chbd_pkg::*;

  logic vld_r;
  res_t res_r;

  // the slot can be refilled when empty or when its beat leaves now
  assign free             = ~vld_r | ~out_stall;
  assign out_valid        = vld_r;
  assign out_kind         = res_r.kind;
  assign out_payload_byte = res_r.payload_byte;
  assign out_body_length  = res_r.body_length;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (step) begin
      vld_r <= res_vld;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      res_r <= res;
    end
  end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// top level of the chunked transfer body decoder
// Decodes an HTTP/1.1 chunked body one byte per cycle, sustained as long as
// the result register is not full and stalled.
// Each byte passes through an input register, one step of the parser state
// machine, and a result register; the state machine step is the only work
// between the two, so a new byte is taken every cycle unless the result
// register is full and stalled. Payload bytes come out as they arrive; a
// body ends with one success beat carrying the total length, or one failure
// beat on the first error, after which bytes are dropped until the final
// byte. Payload seen before a failure must be discarded by the consumer.
// body_limit is written over the cfg port, always ready; the user must write
// it only while the decoder is idle, as the block does not enforce it.
module http_chunked_body_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_body_byte,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [31:0] out_body_length
);
  import chbd_pkg::*;

  logic  in_vld;
  beat_t beat;
  logic  out_free;
  logic  take;
  logic  res_vld;
  res_t  res;

  assign cfg_ready = 1'b1;
  // a held beat is parsed when the result slot can take its outcome
  assign take = in_vld & out_free;

  // input register
  chbd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_body_byte (in_body_byte),
    .in_is_final  (in_is_final),
    .take         (take),
    .vld          (in_vld),
    .beat         (beat)
  );

  // parser
  chbd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .step     (take),
    .beat     (beat),
    .res_vld  (res_vld),
    .res      (res)
  );

  // result register
  chbd_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (take),
    .res_vld          (res_vld),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_body_length  (out_body_length)
  );

  // payload byte is zero on every non-payload beat
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_payload_byte == 8'd0))
    else $error("payload byte set on a non-payload beat");

  // length is zero unless the beat reports success
  a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_OK) |-> (out_body_length == 32'd0))
    else $error("body length set on a beat that is not success");

  // input never stalls while the result side is drained
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with a free result slot");

endmodule
